// ----- src/mmrs_pkg.sv -----
// Shared widths, constants and state codes for the min/max byte rescale unit.
package mmrs_pkg;

	localparam int PIX_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int NUM_W   = PIX_W + BYTE_W;
	localparam int CNT_W   = $clog2(BYTE_W);

	localparam logic [BYTE_W-1:0] FULL_SCALE = 8'd255;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [NUM_W-1:0]  num_t;

	// divider request from the sequencer
	typedef struct packed {
		logic start;
		num_t num;
		pix_t den;
	} div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic  done;
		byte_t quot;
	} div_rsp_t;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_WAIT = 2'd3;

endpackage

// ----- src/mmrs_divider.sv -----
// Restoring divider, one quotient bit per cycle, for quotients below 256.
module mmrs_divider import mmrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	pix_t             rem_q;
	pix_t             den_q;
	byte_t            qn_q;
	logic [PIX_W:0]   trial;
	logic             qbit;

	// numerator bits shift out of the top of qn_q while quotient bits enter below
	assign trial = {rem_q, qn_q[BYTE_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(BYTE_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BYTE_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-1:BYTE_W];
			qn_q  <= req.num[BYTE_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= qbit ? PIX_W'(trial - {1'b0, den_q}) : trial[PIX_W-1:0];
			qn_q  <= {qn_q[BYTE_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = qn_q;

endmodule

// ----- src/min_max_to_byte_rescale_unit.sv -----
// Top level: min/max mark gathering and 16-to-8 bit contrast stretch.
// Gather requests update the marks in S_IDLE; the unit is ready again on the next cycle.
// Convert requests go from accept through S_PREP to the result register, passing
// the one-bit-per-cycle divider (S_DIV) only when the range is non-empty and the
// pixel lies strictly between the marks; one request is in work at a time.
// Reset puts the low mark at 255, the high mark at 0 and clears all valid flags.
module min_max_to_byte_rescale_unit import mmrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  logic  mode,
	input  pix_t  pixel,
	input  logic  first,
	output logic  out_valid,
	input  logic  out_stall,
	output byte_t byte_out
);

	logic [1:0] state_q;
	byte_t      low_q;
	pix_t       high_q;
	pix_t       pix_q;
	byte_t      res_q;
	logic       out_valid_q;
	byte_t      byte_out_q;

	logic       in_acc;
	logic       out_free;
	byte_t      low_base;
	pix_t       high_base;
	logic       empty_range;
	logic       below;
	logic       above;
	pix_t       diff;
	num_t       num;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign low_base  = first ? FULL_SCALE : low_q;
	assign high_base = first ? '0 : high_q;

	assign empty_range = (high_q <= {8'd0, low_q});
	assign below       = (pix_q <= {8'd0, low_q});
	assign above       = (pix_q >= high_q);
	assign diff        = pix_q - {8'd0, low_q};
	// 255 * diff as a shift and subtract
	assign num         = {diff, 8'd0} - {8'd0, diff};

	assign div_req.start = (state_q == S_PREP) && !(empty_range || below || above);
	assign div_req.num   = num;
	assign div_req.den   = high_q - {8'd0, low_q};

	mmrs_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_q       <= FULL_SCALE;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_WAIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!mode) begin
							high_q <= (pixel > high_base) ? pixel : high_base;
							low_q  <= (pixel < {8'd0, low_base}) ? pixel[BYTE_W-1:0]
							                                     : low_base;
						end else begin
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					state_q <= div_req.start ? S_DIV : S_WAIT;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q <= pixel;
		end
		if (state_q == S_PREP && !div_req.start) begin
			priority if (empty_range) begin
				res_q <= pix_q[BYTE_W-1:0];
			end else if (below) begin
				res_q <= '0;
			end else begin
				res_q <= FULL_SCALE;
			end
		end else if (state_q == S_DIV && div_rsp.done) begin
			res_q <= div_rsp.quot;
		end
		if (state_q == S_WAIT && out_free) begin
			byte_out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign byte_out  = byte_out_q;

endmodule
